// ===== design/slcan_pkg.sv =====
// ----------------------------------------------------------------------------
// slcan_pkg
// Shared types, character codes and the hex digit decode for the serial
// ASCII CAN frame line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package slcan_pkg;

    // largest payload a line may announce
    localparam int unsigned MAX_PAYLOAD_BYTES = 8;

    localparam int unsigned IN_TDATA_W  = 8;
    // is_extended + frame_id + data_length + payload = 101 bits, padded to bytes
    localparam int unsigned OUT_TDATA_W = 104;

    // character codes
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_STD = 8'h74;  // 't'
    localparam logic [7:0] CHAR_EXT = 8'h54;  // 'T'

    // id digit counts for the two line kinds
    localparam logic [3:0] ID_DIGITS_STD = 4'd3;
    localparam logic [3:0] ID_DIGITS_EXT = 4'd8;

    // saturation point of the character position
    localparam logic [4:0] POS_MAX = 5'd31;

    // kind of the line seen so far
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_STD   = 2'd1,
        KIND_EXT   = 2'd2,
        KIND_OTHER = 2'd3
    } line_kind_t;

    // one decoded CAN frame
    typedef struct packed {
        logic [63:0] payload;
        logic [3:0]  data_length;
        logic [31:0] frame_id;
        logic        is_extended;
    } can_frame_t;

    // decoder to output register
    typedef struct packed {
        logic       load;   // stage moved an item on
        logic       emit;   // that item closed a well-formed line
        can_frame_t frame;
    } dec_result_t;

    // hex digit value; bit 4 set for a non-hex character
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h41 + 8'd10)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h61 + 8'd10)};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/slcan_ascii_frame_parser.sv =====
// ----------------------------------------------------------------------------
// slcan_ascii_frame_parser
// m_axis_tvalid rises once the carriage return ending the line has passed the
// input register, the combinational decode and the result register.
// Throughput: one character per cycle; only a frame held in the result register
// by a low m_axis_tready stalls the input.
// Reset: synchronous active-low aresetn clears the valid flags and line state.
// ----------------------------------------------------------------------------
`default_nettype none

module slcan_ascii_frame_parser (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [slcan_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [7:0] rx_byte
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [0] is_extended, [32:1] frame_id, [36:33] data_length, [100:37] payload,
    // [103:101] zero
    output logic [slcan_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
    import slcan_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;
    logic        fire;
    dec_result_t result;
    can_frame_t  m_frame;

    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // character decode and line state
    slcan_line_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    // result register
    slcan_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .result  (result),
        .advance (advance),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_frame (m_frame)
    );

    assign m_axis_tdata = {3'b000, m_frame.payload, m_frame.data_length,
                           m_frame.frame_id, m_frame.is_extended};

    // a frame is only produced by a carriage return
    a_emit_on_cr: assert property (@(posedge aclk) disable iff (!aresetn)
        (result.load && result.emit) |-> (in_byte_reg == CHAR_CR))
        else $error("frame emitted on a character other than carriage return");

    // announced length never exceeds the payload size
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_frame.data_length <= 4'(MAX_PAYLOAD_BYTES)))
        else $error("data length above the payload size");

    // a standard frame id has only three hex digits
    a_std_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_frame.is_extended) |-> (m_frame.frame_id[31:12] == 20'd0))
        else $error("standard frame id wider than 12 bits");

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

// ===== design/slcan_line_decoder.sv =====
// ----------------------------------------------------------------------------
// slcan_line_decoder
// Holds the per-line parse state and decodes one character per cycle while
// fire is high, flagging a frame when a carriage return closes a well-formed line.
// ----------------------------------------------------------------------------
`default_nettype none

module slcan_line_decoder (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   fire,      // character present and moving on
    input  wire logic [7:0]             rx_byte,
    output slcan_pkg::dec_result_t      result
);
    import slcan_pkg::*;

    logic [4:0]  pos_reg,       pos_next;
    line_kind_t  kind_reg,      kind_next;
    logic [31:0] id_reg,        id_next;
    logic [3:0]  len_reg,       len_next;
    logic [63:0] payload_reg,   payload_next;
    logic        malformed_reg, malformed_next;

    logic [4:0]  digit;
    logic        is_hex;
    logic        is_cr;
    logic [3:0]  id_len;
    logic        active;
    logic [4:0]  need;
    logic [4:0]  data_pos;
    logic [3:0]  byte_idx;
    logic [3:0]  nibble_idx;

    // character classification and line geometry
    always_comb begin
        digit      = hex_value(rx_byte);
        is_hex     = ~digit[4];
        is_cr      = (rx_byte == CHAR_CR);
        id_len     = (kind_reg == KIND_EXT) ? ID_DIGITS_EXT : ID_DIGITS_STD;
        active     = ((kind_reg == KIND_STD) || (kind_reg == KIND_EXT)) && !malformed_reg;
        need       = 5'd2 + {1'b0, id_len} + {len_reg, 1'b0};
        data_pos   = pos_reg - ({1'b0, id_len} + 5'd2);
        byte_idx   = data_pos[4:1];
        // high nibble comes first
        nibble_idx = {byte_idx[2:0], ~data_pos[0]};
    end

    // next line state
    always_comb begin
        pos_next       = pos_reg;
        kind_next      = kind_reg;
        id_next        = id_reg;
        len_next       = len_reg;
        payload_next   = payload_reg;
        malformed_next = malformed_reg;
        if (fire) begin
            if (is_cr) begin
                pos_next       = '0;
                kind_next      = KIND_NONE;
                id_next        = '0;
                len_next       = '0;
                payload_next   = '0;
                malformed_next = 1'b0;
            end else begin
                if (pos_reg == 5'd0) begin
                    if (rx_byte == CHAR_STD) begin
                        kind_next = KIND_STD;
                    end else if (rx_byte == CHAR_EXT) begin
                        kind_next = KIND_EXT;
                    end else begin
                        kind_next = KIND_OTHER;
                    end
                end else if (active) begin
                    if (pos_reg <= {1'b0, id_len}) begin
                        if (!is_hex) begin
                            malformed_next = 1'b1;
                        end else begin
                            id_next = {id_reg[27:0], digit[3:0]};
                        end
                    end else if (pos_reg == ({1'b0, id_len} + 5'd1)) begin
                        if (!is_hex || (digit[3:0] > 4'(MAX_PAYLOAD_BYTES))) begin
                            malformed_next = 1'b1;
                        end else begin
                            len_next = digit[3:0];
                        end
                    end else if (byte_idx < len_reg) begin
                        if (!is_hex) begin
                            malformed_next = 1'b1;
                        end else begin
                            for (int n = 0; n < 16; n++) begin
                                if (nibble_idx == 4'(n)) begin
                                    payload_next[4*n +: 4] = payload_reg[4*n +: 4] | digit[3:0];
                                end
                            end
                        end
                    end
                end
                if (pos_reg < POS_MAX) begin
                    pos_next = pos_reg + 5'd1;
                end
            end
        end
    end

    // line state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            kind_reg      <= KIND_NONE;
            id_reg        <= '0;
            len_reg       <= '0;
            payload_reg   <= '0;
            malformed_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            kind_reg      <= kind_next;
            id_reg        <= id_next;
            len_reg       <= len_next;
            payload_reg   <= payload_next;
            malformed_reg <= malformed_next;
        end
    end

    // frame out on a carriage return that closes a complete line
    always_comb begin
        result.load              = fire;
        result.emit              = fire && is_cr && active && (pos_reg >= need);
        result.frame.is_extended = (kind_reg == KIND_EXT);
        result.frame.frame_id    = id_reg;
        result.frame.data_length = len_reg;
        result.frame.payload     = payload_reg;
    end

endmodule

`default_nettype wire

// ===== design/slcan_out_reg.sv =====
// ----------------------------------------------------------------------------
// slcan_out_reg
// Result register of the parser: holds one decoded frame until the
// downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module slcan_out_reg (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire slcan_pkg::dec_result_t result,
    output logic                        advance,   // register can take a new item
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output slcan_pkg::can_frame_t       m_frame
);
    import slcan_pkg::*;

    logic       valid_reg;
    can_frame_t frame_reg;

    assign advance = !valid_reg || m_ready;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= result.load && result.emit;
        end
    end

    // frame payload, no reset needed
    always_ff @(posedge aclk) begin
        if (advance && result.load && result.emit) begin
            frame_reg <= result.frame;
        end
    end

    assign m_valid = valid_reg;
    assign m_frame = frame_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the serial ASCII CAN frame line parser. Lines of
// characters go in one item at a time with random gaps and the frames that
// come out, under random back-pressure, are compared field by field with a
// line decoder kept inside the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slcan_pkg::*;

    // cycles with no accepted item on either side before giving up
    localparam int unsigned IDLE_LIMIT   = 500;
    localparam int unsigned RANDOM_CHARS = 960;
    localparam int unsigned DRAIN_CYCLES = 20;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] rx_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [0] is_extended, [32:1] frame_id, [36:33] data_length, [100:37] payload
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // line decoder state kept by the bench
    int unsigned line_pos;
    line_kind_t  line_kind;
    logic [31:0] id_acc;
    logic [3:0]  announced_len;
    logic [63:0] payload_acc;
    bit          line_bad;

    can_frame_t  pending_frames[$];
    logic [7:0]  line_chars[$];
    int unsigned chars_sent  = 0;
    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;
    bit          no_gaps     = 1'b0;

    slcan_ascii_frame_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hex digit value, -1 for anything else
    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        return -1;
    endfunction

    function automatic void restart_line();
        line_pos      = 0;
        line_kind     = KIND_NONE;
        id_acc        = '0;
        announced_len = '0;
        payload_acc   = '0;
        line_bad      = 1'b0;
    endfunction

    // advance the line decoder by one character, queue a frame on a good line end
    function automatic void decode_char(input logic [7:0] c);
        int unsigned id_len;
        int unsigned need;
        int unsigned k;
        int unsigned slot;
        int          d;
        bit          framed;
        can_frame_t  f;
        id_len = (line_kind == KIND_EXT) ? 8 : 3;
        framed = (line_kind == KIND_STD || line_kind == KIND_EXT);
        if (c == CHAR_CR) begin
            need = 2 + id_len + 2 * announced_len;
            if (framed && !line_bad && line_pos >= need) begin
                f.is_extended = (line_kind == KIND_EXT);
                f.frame_id    = id_acc;
                f.data_length = announced_len;
                f.payload     = payload_acc;
                pending_frames.push_back(f);
            end
            restart_line();
        end else begin
            if (line_pos == 0) begin
                line_kind = (c == CHAR_STD) ? KIND_STD :
                            (c == CHAR_EXT) ? KIND_EXT : KIND_OTHER;
            end else if (framed && !line_bad) begin
                d = nibble_of(c);
                if (line_pos <= id_len) begin
                    // id digits, most significant first
                    if (d < 0) line_bad = 1'b1;
                    else id_acc = {id_acc[27:0], d[3:0]};
                end else if (line_pos == id_len + 1) begin
                    if (d < 0 || d > int'(MAX_PAYLOAD_BYTES)) line_bad = 1'b1;
                    else announced_len = d[3:0];
                end else begin
                    // data digits, high nibble of each byte first
                    k    = line_pos - (id_len + 2);
                    slot = k / 2;
                    if (slot < announced_len) begin
                        if (d < 0) line_bad = 1'b1;
                        else payload_acc[8 * slot + ((k % 2 == 0) ? 4 : 0) +: 4] = d[3:0];
                    end
                end
            end
            if (line_pos < 31) line_pos++;
        end
    endfunction

    function automatic int unsigned draw_gap();
        if (no_gaps || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 18);
    endfunction

    // one character across the input handshake
    task automatic send_char(input logic [7:0] c);
        int unsigned gap;
        gap = draw_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge aclk); while (!s_axis_tready);
        decode_char(c);
        chars_sent++;
    endtask

    // close the line being built with a carriage return and send it
    task automatic send_line();
        line_chars.push_back(CHAR_CR);
        foreach (line_chars[i]) send_char(line_chars[i]);
        line_chars.delete();
    endtask

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) line_chars.push_back(8'(s[i]));
    endfunction

    task automatic send_text(input string s);
        push_text(s);
        send_line();
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'h30 + 8'(v);
        return (($urandom_range(0, 1) == 1) ? 8'h61 : 8'h41) + 8'(v - 10);
    endfunction

    // any byte that is neither a hex digit nor a carriage return
    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CHAR_CR || nibble_of(b) >= 0);
        return b;
    endfunction

    task automatic record_mismatch(input string what, input logic [63:0] want_v,
                                   input logic [63:0] got_v);
        if (mismatches < 10) begin
            $display("%0t: mismatch %s: expected %h, got %h", $time, what, want_v, got_v);
        end
        mismatches++;
    endtask

    // result side: random back-pressure and the frame check
    initial begin : frame_check
        int unsigned hold;
        can_frame_t  got;
        can_frame_t  want;
        hold = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_axis_tready <= (hold == 0);
            if (hold != 0) hold--;
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(can_frame_t)-1:0];
                if (pending_frames.size() == 0) begin
                    record_mismatch("frame with none pending, id", '0, 64'(got.frame_id));
                end else begin
                    want = pending_frames.pop_front();
                    if (got.is_extended !== want.is_extended) begin
                        record_mismatch("is_extended", 64'(want.is_extended),
                                        64'(got.is_extended));
                    end
                    if (got.frame_id !== want.frame_id) begin
                        record_mismatch("frame_id", 64'(want.frame_id), 64'(got.frame_id));
                    end
                    if (got.data_length !== want.data_length) begin
                        record_mismatch("data_length", 64'(want.data_length),
                                        64'(got.data_length));
                    end
                    if (got.payload !== want.payload) begin
                        record_mismatch("payload", want.payload, got.payload);
                    end
                end
                hold = draw_gap();
            end
        end
    end

    // watchdog on stalled traffic
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // well-formed frames, both kinds, extremes of id, length and payload
    task automatic test_good_frames();
        send_text("t0000");
        send_text("t7FF1a5");
        send_text("TFFFFFFFF8ffffffffFFFFFFFF");
        send_text("T000000000");
        send_text("t1238DeadBeef01234567");
    endtask

    // lines that must give no frame, plus ignored trailing characters
    task automatic test_odd_lines();
        send_text("");
        send_text("x123");
        send_text("t");
        send_text("t12G0");
        send_text("t1239");
        send_text("t123x");
        send_text("t1232AB");
        send_text("t1232ABgz");
        send_text("t1231ABxyz");
        // long line, position saturates past every needed character
        send_text("T1234abcd80011223344556677zzzzzzzzzzzzzzzz");
        // byte extremes after the needed characters and as a first character
        push_text("t00010A");
        line_chars.push_back(8'hFF);
        line_chars.push_back(8'h00);
        send_line();
        line_chars.push_back(8'hFF);
        push_text("1230");
        send_line();
    endtask

    // random lines: mostly well-formed, some broken and some noise
    task automatic test_random_traffic();
        int unsigned stop_at;
        int unsigned ndig;
        int unsigned len;
        int unsigned need;
        int unsigned extras;
        bit          ext;
        logic [31:0] id;
        stop_at = chars_sent + RANDOM_CHARS;
        while (chars_sent < stop_at) begin
            no_gaps = ($urandom_range(0, 7) == 0);
            ext  = $urandom_range(0, 1);
            ndig = ext ? 8 : 3;
            id   = $urandom;
            len  = $urandom_range(0, MAX_PAYLOAD_BYTES);
            need = 2 + ndig + 2 * len;
            line_chars.push_back(ext ? CHAR_EXT : CHAR_STD);
            for (int i = ndig - 1; i >= 0; i--) line_chars.push_back(hex_char(id[4 * i +: 4]));
            line_chars.push_back(hex_char(len));
            for (int i = 0; i < 2 * len; i++) line_chars.push_back(hex_char($urandom_range(0, 15)));
            // trailing characters, now and then past the saturation point
            extras = ($urandom_range(0, 9) < 7) ? 0 :
                     ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) :
                                                   $urandom_range(1, 12);
            repeat (extras) begin
                line_chars.push_back(($urandom_range(0, 1) == 1) ? junk_byte() :
                                     hex_char($urandom_range(0, 15)));
            end
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 4))
                    0: line_chars[$urandom_range(1, need - 1)] = junk_byte();
                    1: line_chars[ndig + 1] = hex_char($urandom_range(9, 15));
                    2: begin
                        len = $urandom_range(0, need - 1);
                        while (line_chars.size() > len) void'(line_chars.pop_back());
                    end
                    3: begin
                        do line_chars[0] = 8'($urandom_range(0, 255));
                        while (line_chars[0] inside {CHAR_CR, CHAR_STD, CHAR_EXT});
                    end
                    default: begin
                        line_chars.delete();
                        repeat ($urandom_range(0, 35)) begin
                            line_chars.push_back(($urandom_range(0, 1) == 1) ? junk_byte() :
                                                 hex_char($urandom_range(0, 15)));
                        end
                    end
                endcase
            end
            send_line();
        end
        no_gaps = 1'b0;
    endtask

    // main sequence
    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        restart_line();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_good_frames();
        test_odd_lines();
        test_random_traffic();

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_frames.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/slcan_pkg.sv
design/slcan_line_decoder.sv
design/slcan_out_reg.sv
design/slcan_ascii_frame_parser.sv
tb/sv/tb.sv
